FILE: sv/periodic_task_timer_table_assert.svh
// Assertion macros used by the checker file of this block.
// Each macro expands to one labeled concurrent assertion with
// an asynchronous active-low reset as the disable condition.
`ifndef PERIODIC_TASK_TIMER_TABLE_ASSERT_SVH
`define PERIODIC_TASK_TIMER_TABLE_ASSERT_SVH

// Same-cycle implication: whenever ante holds, cons holds too.
`define PTT_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("ptt assertion failed");

// Next-cycle implication: whenever ante holds, cons holds in the next cycle.
`define PTT_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("ptt assertion failed");

`endif

FILE: sv/ptt_pkg.sv
// ----------------------------------------------------------------------------
// ptt_pkg
// Shared types and constants of the periodic task timer table.
// ----------------------------------------------------------------------------
package ptt_pkg;

  localparam int TaskCount  = 8;
  localparam int TaskIdxW   = (TaskCount > 1) ? $clog2(TaskCount) : 1;
  localparam int IdxInW     = 4;
  localparam int TimeW      = 32;
  localparam int MaskW      = 8;
  localparam int QueueDepth = 2;
  localparam int QPtrW      = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int QCntW      = $clog2(QueueDepth + 1);

  typedef enum logic [1:0] {
    MODE_PASS         = 2'd0,
    MODE_ENABLE       = 2'd1,
    MODE_DISABLE      = 2'd2,
    MODE_SET_INTERVAL = 2'd3
  } mode_e;

  localparam logic [1:0] STATUS_DISABLED = 2'd0;
  localparam logic [1:0] STATUS_ENABLED  = 2'd1;
  localparam logic [1:0] STATUS_UNKNOWN  = 2'd2;

  typedef struct packed {
    logic [1:0]        mode;
    logic [IdxInW-1:0] task_index;
    logic              run_now;
    logic [TimeW-1:0]  interval_value;
    logic [TimeW-1:0]  now_time;
  } in_item_t;

  typedef struct packed {
    logic [MaskW-1:0] fired_mask;
    logic             index_valid;
    logic [1:0]       task_status;
  } out_item_t;

  // Classified command handed from the front end to the back end.
  typedef struct packed {
    mode_e               mode;
    logic                idx_valid;
    logic [TaskIdxW-1:0] idx;
    logic                run_now;
    logic [TimeW-1:0]    interval;
    logic [TimeW-1:0]    now;
  } cmd_t;

endpackage

FILE: sv/ptt_front.sv
// ----------------------------------------------------------------------------
// ptt_front
// Input stage: takes transactions, decodes the mode and checks the index.
// ----------------------------------------------------------------------------
module ptt_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  ptt_pkg::in_item_t in_data_i,
  output logic             push_valid_o,
  input  logic             push_ready_i,
  output ptt_pkg::cmd_t    push_cmd_o
);

  logic          slot_valid_q, slot_valid_d;
  ptt_pkg::cmd_t slot_q, slot_d;
  logic          idx_ok;

  assign idx_ok     = {1'b0, in_data_i.task_index} < (ptt_pkg::IdxInW + 1)'(ptt_pkg::TaskCount);
  assign in_ready_o = !slot_valid_q || push_ready_i;

  always_comb begin
    slot_d           = slot_q;
    slot_valid_d     = slot_valid_q;
    if (slot_valid_q && push_ready_i) begin
      slot_valid_d = 1'b0;
    end
    if (in_valid_i && in_ready_o) begin
      slot_valid_d       = 1'b1;
      slot_d.mode        = ptt_pkg::mode_e'(in_data_i.mode);
      slot_d.idx_valid   = idx_ok;
      slot_d.idx         = in_data_i.task_index[ptt_pkg::TaskIdxW-1:0];
      slot_d.run_now     = in_data_i.run_now;
      slot_d.interval    = in_data_i.interval_value;
      slot_d.now         = in_data_i.now_time;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_valid_q <= 1'b0;
    end else begin
      slot_valid_q <= slot_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    slot_q <= slot_d;
  end

  assign push_valid_o = slot_valid_q;
  assign push_cmd_o   = slot_q;

endmodule

FILE: sv/ptt_queue.sv
// ----------------------------------------------------------------------------
// ptt_queue
// Short command queue between the front end and the back end.
// ----------------------------------------------------------------------------
module ptt_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_valid_i,
  output logic          push_ready_o,
  input  ptt_pkg::cmd_t push_cmd_i,
  output logic          head_valid_o,
  output ptt_pkg::cmd_t head_cmd_o,
  input  logic          pop_i
);

  ptt_pkg::cmd_t                 entry_q [ptt_pkg::QueueDepth];
  logic [ptt_pkg::QPtrW-1:0]     wr_ptr_q, rd_ptr_q;
  logic [ptt_pkg::QCntW-1:0]     count_q;
  logic                          do_push, do_pop;

  assign push_ready_o = count_q != ptt_pkg::QCntW'(ptt_pkg::QueueDepth);
  assign head_valid_o = count_q != '0;
  assign head_cmd_o   = entry_q[rd_ptr_q];
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_i && head_valid_o;

  function automatic logic [ptt_pkg::QPtrW-1:0] next_ptr(input logic [ptt_pkg::QPtrW-1:0] p);
    logic [ptt_pkg::QPtrW-1:0] r;
    if (p == ptt_pkg::QPtrW'(ptt_pkg::QueueDepth - 1)) begin
      r = '0;
    end else begin
      r = p + 1'b1;
    end
    return r;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= next_ptr(wr_ptr_q);
      end
      if (do_pop) begin
        rd_ptr_q <= next_ptr(rd_ptr_q);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (!do_push && do_pop) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule

FILE: sv/ptt_back.sv
// ----------------------------------------------------------------------------
// ptt_back
// Execution stage: holds the task table, runs commands, scans one task entry
// per cycle for a pass and loads the output register, waiting for it to be free.
// ----------------------------------------------------------------------------
module ptt_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               head_valid_i,
  input  ptt_pkg::cmd_t      head_cmd_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output ptt_pkg::out_item_t out_data_o
);

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } state_e;

  state_e                          state_q;
  logic [ptt_pkg::TaskIdxW-1:0]    cnt_q;
  logic [ptt_pkg::MaskW-1:0]       fired_q, fired_d;
  logic [ptt_pkg::TaskCount-1:0]   enabled_q;
  logic [ptt_pkg::TimeW-1:0]       interval_q [ptt_pkg::TaskCount];
  logic [ptt_pkg::TimeW-1:0]       last_q     [ptt_pkg::TaskCount];
  logic                            out_valid_q;
  ptt_pkg::out_item_t              out_q, result;

  logic [ptt_pkg::TaskIdxW-1:0]    rd_idx;
  logic [ptt_pkg::TimeW-1:0]       rd_interval, rd_last, elapsed;
  logic                            due, last_cnt, out_free;
  logic                            exec_go, scan_go, done;

  always_comb begin
    rd_idx      = (state_q == ST_SCAN) ? cnt_q : head_cmd_i.idx;
    rd_interval = interval_q[rd_idx];
    rd_last     = last_q[rd_idx];
    elapsed     = head_cmd_i.now - rd_last;
    due         = enabled_q[rd_idx] && (elapsed >= rd_interval);
    last_cnt    = cnt_q == ptt_pkg::TaskIdxW'(ptt_pkg::TaskCount - 1);
    out_free    = !out_valid_q || out_ready_i;
    exec_go     = (state_q == ST_IDLE) && head_valid_i &&
                  (head_cmd_i.mode != ptt_pkg::MODE_PASS) && out_free;
    // The last scan step also loads the result, so it waits for room.
    scan_go     = (state_q == ST_SCAN) && (!last_cnt || out_free);
    done        = exec_go || (scan_go && last_cnt);
  end

  always_comb begin
    fired_d = fired_q;
    for (int b = 0; b < ptt_pkg::MaskW; b++) begin
      if (scan_go && due && (32'(cnt_q) == 32'(b))) begin
        fired_d[b] = 1'b1;
      end
    end
  end

  always_comb begin
    result.fired_mask  = (head_cmd_i.mode == ptt_pkg::MODE_PASS) ? fired_d : '0;
    result.index_valid = head_cmd_i.idx_valid;
    if (!head_cmd_i.idx_valid) begin
      result.task_status = ptt_pkg::STATUS_UNKNOWN;
    end else begin
      case (head_cmd_i.mode)
        ptt_pkg::MODE_ENABLE:  result.task_status = ptt_pkg::STATUS_ENABLED;
        ptt_pkg::MODE_DISABLE: result.task_status = ptt_pkg::STATUS_DISABLED;
        default: begin
          result.task_status = enabled_q[head_cmd_i.idx] ? ptt_pkg::STATUS_ENABLED
                                                         : ptt_pkg::STATUS_DISABLED;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      fired_q     <= '0;
      enabled_q   <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
      for (int i = 0; i < ptt_pkg::TaskCount; i++) begin
        interval_q[i] <= '0;
        last_q[i]     <= '0;
      end
    end else begin
      if (done) begin
        out_valid_q <= 1'b1;
        out_q       <= result;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        ST_IDLE: begin
          if (head_valid_i && (head_cmd_i.mode == ptt_pkg::MODE_PASS)) begin
            state_q <= ST_SCAN;
            cnt_q   <= '0;
            fired_q <= '0;
          end else if (exec_go && head_cmd_i.idx_valid) begin
            case (head_cmd_i.mode)
              ptt_pkg::MODE_ENABLE: begin
                enabled_q[head_cmd_i.idx] <= 1'b1;
                last_q[head_cmd_i.idx]    <= head_cmd_i.run_now ?
                                             head_cmd_i.now - rd_interval : head_cmd_i.now;
              end
              ptt_pkg::MODE_DISABLE: begin
                enabled_q[head_cmd_i.idx] <= 1'b0;
              end
              ptt_pkg::MODE_SET_INTERVAL: begin
                interval_q[head_cmd_i.idx] <= head_cmd_i.interval;
              end
              default: begin
                state_q <= ST_IDLE;
              end
            endcase
          end
        end
        ST_SCAN: begin
          if (scan_go) begin
            fired_q <= fired_d;
            if (due) begin
              last_q[cnt_q] <= head_cmd_i.now;
            end
            if (last_cnt) begin
              state_q <= ST_IDLE;
              cnt_q   <= '0;
            end else begin
              cnt_q   <= cnt_q + 1'b1;
            end
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign pop_o       = done;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

FILE: sv/periodic_task_timer_table.sv
// ----------------------------------------------------------------------------
// periodic_task_timer_table
// Table of periodic tasks with enable, interval and last-fire time.
// ----------------------------------------------------------------------------
// Usage: the input channel (in_valid_i/in_ready_o/in_data_i) carries one
// command per transaction: a scheduler pass with the current time, enable,
// disable or set interval for one task. Every command yields exactly one
// result transaction on the output channel (out_valid_o/out_ready_i/
// out_data_o) with the fired mask, index validity and task status.
// Path: a command passes an input register and a two-entry queue before the
// execution stage runs it and loads its result into the output register.
// Throughput: enable, disable and set interval run at one per cycle while the
// output register has room; a pass holds the execution unit for its scan,
// since it compares one table entry per cycle against the pass time.
// Reset clears all tasks to disabled with zero interval and last time, and
// empties the input register, queue and output register.
// When the receiver stalls, the result is held in the output register; the
// queue and input register keep taking commands until they are full.
// ----------------------------------------------------------------------------
module periodic_task_timer_table (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  ptt_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output ptt_pkg::out_item_t out_data_o
);

  logic          push_valid, push_ready, head_valid, pop;
  ptt_pkg::cmd_t push_cmd, head_cmd;

  ptt_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_data_i    (in_data_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_cmd_o   (push_cmd)
  );

  ptt_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_cmd_i   (push_cmd),
    .head_valid_o (head_valid),
    .head_cmd_o   (head_cmd),
    .pop_i        (pop)
  );

  ptt_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_cmd_i   (head_cmd),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_data_o   (out_data_o)
  );

endmodule

FILE: sv/ptt_checker.sv
// ----------------------------------------------------------------------------
// ptt_checker
// Port-level checks of the periodic task timer table, bound to the top level.
// ----------------------------------------------------------------------------
`include "periodic_task_timer_table_assert.svh"

module ptt_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input ptt_pkg::in_item_t  in_data_i,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input ptt_pkg::out_item_t out_data_o
);

  logic status_ok, code_ok, mask_ok;

  assign status_ok = out_data_o.index_valid ==
                     (out_data_o.task_status != ptt_pkg::STATUS_UNKNOWN);
  assign code_ok   = (out_data_o.task_status == ptt_pkg::STATUS_DISABLED) ||
                     (out_data_o.task_status == ptt_pkg::STATUS_ENABLED) ||
                     (out_data_o.task_status == ptt_pkg::STATUS_UNKNOWN);
  assign mask_ok   = (9'(out_data_o.fired_mask) >> ptt_pkg::TaskCount) == 9'd0;

  // A transaction that waits on the input keeps its payload.
  `PTT_ASSERT_NXT(a_in_hold, clk_i, rst_ni, in_valid_i && !in_ready_o, in_valid_i && $stable(in_data_i))

  // A result that is not taken stays offered.
  `PTT_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o)

  // The status code reports an unknown index exactly when the index is invalid.
  `PTT_ASSERT_IMP(a_status_valid, clk_i, rst_ni, out_valid_o, status_ok)

  // Only the three defined status codes appear.
  `PTT_ASSERT_IMP(a_status_code, clk_i, rst_ni, out_valid_o, code_ok)

  // Tasks beyond the table never show up in the fired mask.
  `PTT_ASSERT_IMP(a_mask_range, clk_i, rst_ni, out_valid_o, mask_ok)

endmodule

bind periodic_task_timer_table ptt_checker u_ptt_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

FILE: verif/periodic_task_timer_table_tb.sv
// ----------------------------------------------------------------------------
// periodic_task_timer_table_tb
// Self-checking testbench for the periodic task timer table. A scoreboard
// keeps its own copy of the task table, predicts the report of every
// accepted command and compares it with each result transaction. Directed
// cases cover the corners of the table, then a long run of random schedules
// with random idling on both channels.
// ----------------------------------------------------------------------------
module periodic_task_timer_table_tb;
  import ptt_pkg::*;

  localparam int CycleLimit = 400000;
  localparam int MaxIdle    = 13;

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_ready_o;
  in_item_t  in_data_i;
  logic      out_valid_o;
  logic      out_ready_i;
  out_item_t out_data_o;

  // Scoreboard copy of the task table.
  logic             task_on     [TaskCount];
  logic [TimeW-1:0] task_period [TaskCount];
  logic [TimeW-1:0] task_last   [TaskCount];

  out_item_t        pending_reports[$];
  int               mismatch_count;
  int               cycle_count;
  bit               idle_on;
  logic [TimeW-1:0] now_tick;

  periodic_task_timer_table u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Applies one command to the table copy and returns the report it causes.
  function automatic out_item_t predict_task_report(in_item_t cmd);
    out_item_t        rep;
    logic             hit;
    logic [MaskW-1:0] fired;
    hit   = cmd.task_index < TaskCount;
    fired = '0;
    case (mode_e'(cmd.mode))
      MODE_PASS: begin
        for (int i = 0; i < TaskCount; i++) begin
          if (task_on[i] && (cmd.now_time - task_last[i]) >= task_period[i]) begin
            task_last[i] = cmd.now_time;
            if (i < MaskW) fired[i] = 1'b1;
          end
        end
      end
      MODE_ENABLE: begin
        if (hit) begin
          task_on[cmd.task_index]   = 1'b1;
          task_last[cmd.task_index] = cmd.run_now ?
              cmd.now_time - task_period[cmd.task_index] : cmd.now_time;
        end
      end
      MODE_DISABLE: begin
        if (hit) task_on[cmd.task_index] = 1'b0;
      end
      default: begin
        if (hit) task_period[cmd.task_index] = cmd.interval_value;
      end
    endcase
    rep.fired_mask  = fired;
    rep.index_valid = hit;
    if (!hit) rep.task_status = STATUS_UNKNOWN;
    else rep.task_status = task_on[cmd.task_index] ? STATUS_ENABLED : STATUS_DISABLED;
    return rep;
  endfunction

  // Scoreboard: compares each result transaction and records each accepted command.
  always @(posedge clk_i) begin : scoreboard
    out_item_t want;
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("%0t timeout with %0d results outstanding", $time, pending_reports.size());
      $display("Mismatches found");
      $finish;
    end
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_reports.size() == 0) begin
        $display("%0t unexpected result, expected none, actual %h", $time, out_data_o);
        mismatch_count++;
      end else begin
        want = pending_reports.pop_front();
        if (out_data_o.fired_mask !== want.fired_mask) begin
          $display("%0t fired_mask expected %h actual %h", $time, want.fired_mask,
                   out_data_o.fired_mask);
          mismatch_count++;
        end
        if (out_data_o.index_valid !== want.index_valid) begin
          $display("%0t index_valid expected %b actual %b", $time, want.index_valid,
                   out_data_o.index_valid);
          mismatch_count++;
        end
        if (out_data_o.task_status !== want.task_status) begin
          $display("%0t task_status expected %0d actual %0d", $time, want.task_status,
                   out_data_o.task_status);
          mismatch_count++;
        end
      end
    end
    if (rst_ni && in_valid_i && in_ready_o) begin
      pending_reports.push_back(predict_task_report(in_data_i));
    end
  end

  // Receiver: when idling is on, drops ready for a random stall before each result.
  initial begin : receiver
    int stall;
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      stall = idle_on ? $urandom_range(0, MaxIdle) : 0;
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!(out_valid_o && out_ready_i));
    end
  end

  // Sends one command and returns at the edge where the transaction completes.
  task automatic issue_command(input mode_e m, input logic [IdxInW-1:0] idx,
                               input logic rn, input logic [TimeW-1:0] ivl,
                               input logic [TimeW-1:0] now);
    in_item_t cmd;
    int       gap;
    cmd.mode           = m;
    cmd.task_index     = idx;
    cmd.run_now        = rn;
    cmd.interval_value = ivl;
    cmd.now_time       = now;
    gap = idle_on ? $urandom_range(0, MaxIdle) : 0;
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= cmd;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // Takes the last transaction off the input before the sender waits.
  task automatic release_input();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
  endtask

  // Right after reset every task is disabled and nothing fires.
  task automatic check_reset_state();
    issue_command(MODE_PASS, 4'd0, 1'b0, 32'h0, 32'hFFFF_FFFF);
    issue_command(MODE_PASS, 4'd15, 1'b1, 32'hFFFF_FFFF, 32'h0);
    issue_command(MODE_DISABLE, 4'd3, 1'b0, 32'h0, 32'h0);
    issue_command(MODE_PASS, 4'd7, 1'b0, 32'h0, 32'h8000_0000);
    release_input();
    wait (pending_reports.size() == 0);
  endtask

  task automatic check_directed_cases();
    // A zero interval fires on every pass.
    issue_command(MODE_SET_INTERVAL, 4'd0, 1'b0, 32'h0, 32'd100);
    issue_command(MODE_ENABLE, 4'd0, 1'b0, 32'h0, 32'd100);
    issue_command(MODE_PASS, 4'd0, 1'b0, 32'h0, 32'd100);
    issue_command(MODE_PASS, 4'd0, 1'b0, 32'h0, 32'd100);
    // Largest interval with run-now wraps the last time below zero.
    issue_command(MODE_SET_INTERVAL, 4'd1, 1'b0, 32'hFFFF_FFFF, 32'h0);
    issue_command(MODE_ENABLE, 4'd1, 1'b1, 32'h0, 32'd5);
    issue_command(MODE_PASS, 4'd1, 1'b0, 32'h0, 32'd5);
    issue_command(MODE_PASS, 4'd1, 1'b0, 32'h0, 32'd6);
    // Time wraps between enable and pass.
    issue_command(MODE_SET_INTERVAL, 4'd7, 1'b0, 32'd10, 32'h0);
    issue_command(MODE_ENABLE, 4'd7, 1'b0, 32'h0, 32'hFFFF_FFFA);
    issue_command(MODE_PASS, 4'd7, 1'b0, 32'h0, 32'd3);
    issue_command(MODE_PASS, 4'd7, 1'b0, 32'h0, 32'd4);
    // Disabling keeps interval and last time; run-now re-enables at once.
    issue_command(MODE_DISABLE, 4'd7, 1'b0, 32'h0, 32'h0);
    issue_command(MODE_PASS, 4'd7, 1'b0, 32'h0, 32'd100);
    issue_command(MODE_ENABLE, 4'd7, 1'b1, 32'h0, 32'd200);
    issue_command(MODE_PASS, 4'd7, 1'b0, 32'h0, 32'd200);
    issue_command(MODE_ENABLE, 4'd0, 1'b1, 32'h0, 32'hFFFF_FFFF);
    // Out-of-range indexes change nothing and report an unknown status.
    issue_command(MODE_SET_INTERVAL, 4'd8, 1'b0, 32'd1, 32'h0);
    issue_command(MODE_ENABLE, 4'd15, 1'b1, 32'h0, 32'h0);
    issue_command(MODE_DISABLE, 4'd8, 1'b0, 32'h0, 32'h0);
    issue_command(MODE_PASS, 4'd15, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    issue_command(MODE_DISABLE, 4'd0, 1'b0, 32'h0, 32'h0);
    issue_command(MODE_DISABLE, 4'd1, 1'b0, 32'h0, 32'h0);
    issue_command(MODE_DISABLE, 4'd7, 1'b0, 32'h0, 32'h0);
    release_input();
    wait (pending_reports.size() == 0);
  endtask

  // Random schedules: a mostly advancing time base with passes, interval
  // writes, enables and disables, plus some fully random noise commands.
  task automatic check_random_schedules(input int count);
    int               sel;
    logic [IdxInW-1:0] idx;
    logic [TimeW-1:0] ivl;
    now_tick = $urandom;
    for (int n = 0; n < count; n++) begin
      if (n % 100 == 0) begin
        // The sender holds off until every report of the previous chunk is in.
        release_input();
        wait (pending_reports.size() == 0);
        idle_on = ($urandom_range(0, 3) != 0);
      end
      sel = $urandom_range(0, 99);
      idx = ($urandom_range(0, 9) == 0) ? IdxInW'($urandom_range(TaskCount, 2**IdxInW - 1))
                                        : IdxInW'($urandom_range(0, TaskCount - 1));
      case ($urandom_range(0, 9))
        0:       ivl = $urandom;
        1:       ivl = '0;
        default: ivl = $urandom_range(0, 60);
      endcase
      if (sel < 55) begin
        now_tick += ($urandom_range(0, 19) == 0) ? $urandom : $urandom_range(0, 40);
        issue_command(MODE_PASS, idx, 1'($urandom_range(0, 1)), $urandom, now_tick);
      end else if (sel < 70) begin
        issue_command(MODE_SET_INTERVAL, idx, 1'($urandom_range(0, 1)), ivl, $urandom);
      end else if (sel < 82) begin
        issue_command(MODE_ENABLE, idx, 1'($urandom_range(0, 1)), $urandom, now_tick);
      end else if (sel < 88) begin
        issue_command(MODE_DISABLE, idx, 1'($urandom_range(0, 1)), $urandom, $urandom);
      end else begin
        issue_command(mode_e'(2'($urandom_range(0, 3))), IdxInW'($urandom_range(0, 15)),
                      1'($urandom_range(0, 1)), $urandom, $urandom);
      end
    end
  endtask

  initial begin
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    in_data_i      = '0;
    mismatch_count = 0;
    cycle_count    = 0;
    idle_on        = 1'b1;
    for (int i = 0; i < TaskCount; i++) begin
      task_on[i]     = 1'b0;
      task_period[i] = '0;
      task_last[i]   = '0;
    end
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    check_reset_state();
    check_directed_cases();
    check_random_schedules(900);

    @(negedge clk_i);
    in_valid_i <= 1'b0;
    wait (pending_reports.size() == 0);
    repeat (4 * (TaskCount + 3)) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
